@@ src/opd_pkg.sv @@
// Shared types and constants of the oscillator PID discipline block.
// No dependencies; every other file imports this package.
package opd_pkg;

  localparam int unsigned ErrW   = 32;   // phase error
  localparam int unsigned TimeW  = 32;   // millisecond timestamp
  localparam int unsigned GainW  = 48;   // kp/ki/kd
  localparam int unsigned LimW   = 39;   // limits and min step
  localparam int unsigned FreqW  = 40;   // frequency word
  localparam int unsigned AccW   = 64;   // integral accumulator
  localparam int unsigned OpW    = 64;   // multiplicand width
  localparam int unsigned ProdW  = OpW + GainW;   // exact product
  localparam int unsigned Shift  = 16;            // 2^-56 -> 2^-40
  localparam int unsigned TermW  = ProdW - Shift;
  localparam int unsigned SumW   = TermW + 2;
  localparam int unsigned DivW   = ErrW + 1;      // error difference
  localparam int unsigned QuoW   = DivW + 1;      // signed quotient
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [GainW-1:0] KpReset = -48'sd18458530000000;
  localparam logic signed [GainW-1:0] KiReset = -48'sd3938480000;
  localparam logic signed [GainW-1:0] KdReset = 48'sd70723000;
  localparam logic [LimW-1:0] IntLimReset  = '1;
  localparam logic [LimW-1:0] PullLimReset = '1;
  localparam logic [LimW-1:0] MinStepReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_INT_LIM  = 3'd3,
    REG_PULL_LIM = 3'd4,
    REG_MIN_STEP = 3'd5
  } opd_reg_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } opd_term_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INTEG = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_MP    = 8'b0000_1000,
    S_MI    = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_MD    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } opd_state_e;

  typedef struct packed {
    logic      load;       // capture input beat
    logic      integ;      // time step, timestamp, clear sum
    logic      acc;        // integral accumulator update
    logic      mul_start;
    opd_term_e mul_sel;
    logic      add_term;
    opd_term_e add_sel;
    logic      div_start;
    logic      finish;     // decide, update state, load output
  } opd_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic dt_zero;
    logic out_free;
  } opd_sts_t;

endpackage

@@ src/opd_mul.sv @@
// Shift-add signed multiplier, one gain bit per cycle.
// Depends on opd_pkg.
module opd_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [opd_pkg::OpW-1:0]   a_i,
  input  logic signed [opd_pkg::GainW-1:0] b_i,
  output logic                            done_o,
  output logic signed [opd_pkg::ProdW-1:0] prod_o
);
  import opd_pkg::*;

  localparam int unsigned CntW = $clog2(GainW);

  logic                    busy_q, done_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [ProdW-1:0] mcand_q, prod_q;
  logic [GainW-1:0]        mplier_q;
  logic                    last;

  assign last = (cnt_q == CntW'(GainW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= ProdW'(a_i);
      mplier_q <= b_i;
      prod_q   <= '0;
    end else if (busy_q) begin
      // top bit of the gain carries negative weight
      if (mplier_q[0]) prod_q <= last ? prod_q - mcand_q : prod_q + mcand_q;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("multiplier done while busy");
endmodule

@@ src/opd_div.sv @@
// Restoring divider, signed dividend by unsigned divisor, truncating.
// One quotient bit per cycle. Depends on opd_pkg.
module opd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [opd_pkg::DivW-1:0] dividend_i,
  input  logic [opd_pkg::TimeW-1:0]       divisor_i,
  output logic                           done_o,
  output logic signed [opd_pkg::QuoW-1:0] quo_o
);
  import opd_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic             busy_q, done_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivW-1:0]  nq_q;
  logic [TimeW-1:0] rem_q, dsr_q;
  logic [TimeW:0]   trial, trial_sub;
  logic             ge, last;

  assign last      = (cnt_q == CntW'(DivW - 1));
  assign trial     = {rem_q, nq_q[DivW-1]};
  assign ge        = (trial >= {1'b0, dsr_q});
  assign trial_sub = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DivW-1];
      nq_q  <= dividend_i[DivW-1] ? DivW'(-dividend_i) : DivW'(dividend_i);
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[TimeW-1:0] : trial[TimeW-1:0];
      nq_q  <= {nq_q[DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});
endmodule

@@ src/opd_ctrl.sv @@
// Sequencer of the PID block: steps the datapath through one sample.
// Depends on opd_pkg.
module opd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  opd_pkg::opd_sts_t sts_i,
  output opd_pkg::opd_cmd_t cmd_o
);
  import opd_pkg::*;

  opd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = TERM_P;
    cmd_o.add_sel = TERM_P;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd_o.integ = 1'b1;
        state_d     = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = TERM_P;
        state_d         = S_MP;
      end
      S_MP: begin
        if (sts_i.mul_done) begin
          cmd_o.add_term  = 1'b1;
          cmd_o.add_sel   = TERM_P;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = TERM_I;
          state_d         = S_MI;
        end
      end
      S_MI: begin
        if (sts_i.mul_done) begin
          cmd_o.add_term = 1'b1;
          cmd_o.add_sel  = TERM_I;
          if (sts_i.dt_zero) begin
            state_d = S_DONE;   // no derivative on a zero step
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = TERM_D;
          state_d         = S_MD;
        end
      end
      S_MD: begin
        if (sts_i.mul_done) begin
          cmd_o.add_term = 1'b1;
          cmd_o.add_sel  = TERM_D;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == S_MP || state_q == S_MI || state_q == S_MD))
    else $error("multiplier finished outside a multiply step");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");
endmodule

@@ src/opd_datapath.sv @@
// PID datapath: sample registers, controller state, term sum, output register.
// Depends on opd_pkg, opd_mul and opd_div.
module opd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  opd_pkg::opd_cmd_t                cmd_i,
  output opd_pkg::opd_sts_t                sts_o,
  input  logic [63:0]                      in_data_i,
  input  logic signed [opd_pkg::GainW-1:0] kp_i,
  input  logic signed [opd_pkg::GainW-1:0] ki_i,
  input  logic signed [opd_pkg::GainW-1:0] kd_i,
  input  logic [opd_pkg::LimW-1:0]         int_lim_i,
  input  logic [opd_pkg::LimW-1:0]         pull_lim_i,
  input  logic [opd_pkg::LimW-1:0]         min_step_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [opd_pkg::FreqW-1:0]        out_freq_o,
  output logic                             out_applied_o
);
  import opd_pkg::*;

  logic signed [ErrW-1:0]  err_q, prev_err_q;
  logic [TimeW-1:0]        now_q, prev_time_q, dt_q;
  logic signed [AccW-1:0]  iacc_q;
  logic signed [FreqW-1:0] freq_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    out_valid_q, out_applied_q;
  logic [FreqW-1:0]        out_freq_q;

  // integral update
  logic signed [AccW:0]    add_w, acc_sum;
  assign add_w   = (AccW+1)'($signed(err_q) * $signed({1'b0, dt_q}));
  assign acc_sum = {iacc_q[AccW-1], iacc_q} + add_w;

  // shared multiplier
  logic                    mul_done, div_done;
  logic signed [OpW-1:0]   mul_a;
  logic signed [GainW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [QuoW-1:0]  quo;
  logic signed [DivW-1:0]  err_diff;

  assign err_diff = {err_q[ErrW-1], err_q} - {prev_err_q[ErrW-1], prev_err_q};

  always_comb begin
    unique case (cmd_i.mul_sel)
      TERM_P:  begin mul_a = OpW'(err_q);  mul_b = kp_i; end
      TERM_I:  begin mul_a = iacc_q;       mul_b = ki_i; end
      TERM_D:  begin mul_a = OpW'(quo);    mul_b = kd_i; end
      default: begin mul_a = '0;           mul_b = '0;   end
    endcase
  end

  opd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  opd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (err_diff),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // term after the 2^-16 rescale; integral term clamped to its bound
  logic signed [TermW-1:0] term, ilim_pos, term_add;
  assign term     = prod[ProdW-1:Shift];
  assign ilim_pos = $signed(TermW'(int_lim_i));

  always_comb begin
    term_add = term;
    if (cmd_i.add_sel == TERM_I) begin
      if (term > ilim_pos)       term_add = ilim_pos;
      else if (term < -ilim_pos) term_add = -ilim_pos;
    end
  end

  // final decision on the exact sum; 64-bit saturation would not change it
  logic signed [SumW-1:0]  mstep_w, plim_w;
  logic                    big;
  logic signed [FreqW-1:0] freq_new;
  assign mstep_w = $signed(SumW'(min_step_i));
  assign plim_w  = $signed(SumW'(pull_lim_i));
  assign big     = (sum_q >= mstep_w) || (sum_q <= -mstep_w);

  always_comb begin
    if (sum_q >= plim_w)       freq_new = $signed(FreqW'(pull_lim_i));
    else if (sum_q <= -plim_w) freq_new = -$signed(FreqW'(pull_lim_i));
    else                       freq_new = sum_q[FreqW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iacc_q      <= '0;
      prev_err_q  <= '0;
      freq_q      <= '0;
      prev_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.integ) prev_time_q <= now_q;
      if (cmd_i.acc) begin
        if (acc_sum[AccW] != acc_sum[AccW-1])
          iacc_q <= acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        else
          iacc_q <= acc_sum[AccW-1:0];
      end
      if (cmd_i.finish) begin
        prev_err_q <= err_q;
        if (big) freq_q <= freq_new;
      end
      if (cmd_i.finish)                   out_valid_q <= 1'b1;
      else if (out_ready_i && out_valid_q) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= in_data_i[ErrW-1:0];
      now_q <= in_data_i[ErrW+TimeW-1:ErrW];
    end
    if (cmd_i.integ) begin
      dt_q  <= (prev_time_q == '0) ? '0 : now_q - prev_time_q;
      sum_q <= '0;
    end else if (cmd_i.add_term) begin
      sum_q <= sum_q + SumW'(term_add);
    end
    if (cmd_i.finish) begin
      out_freq_q    <= big ? freq_new : freq_q;
      out_applied_q <= big;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_freq_o    = out_freq_q;
  assign out_applied_o = out_applied_q;

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q) else $error("result register not loaded");
endmodule

@@ src/oscillator_pid_discipline.sv @@
// Top level of the oscillator PID discipline block: config registers,
// sequencer and datapath. Depends on opd_pkg, opd_ctrl, opd_datapath.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: phase_error[31:0], now_ms[63:32]
//  m_axis   | out       | tdata: frequency[39:0]; tuser: applied[0]
//  cfg      | in        | cfg_index_i register number, cfg_data_i value
//
// One sample at a time. Each sample runs the bit-serial 64x48 multiplier
// for the P, I and D terms and the divider for the derivative; a zero
// time step skips the divide and the D multiply. The result sits in an
// output register; a stalled m_axis only holds the sequencer at its last
// step. Reset clears state and loads default gains.
// cfg writes are always taken; indexes past the six registers are dropped.
module oscillator_pid_discipline (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // phase_error[31:0], now_ms[63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // frequency[39:0]
  output logic [0:0]  m_axis_tuser_o,   // applied[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [opd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [opd_pkg::GainW-1:0]   cfg_data_i
);
  import opd_pkg::*;

  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic [LimW-1:0]         int_lim_q, pull_lim_q, min_step_q;
  opd_cmd_t                cmd;
  opd_sts_t                sts;
  logic                    applied;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= KpReset;
      ki_q       <= KiReset;
      kd_q       <= KdReset;
      int_lim_q  <= IntLimReset;
      pull_lim_q <= PullLimReset;
      min_step_q <= MinStepReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KP:       kp_q       <= cfg_data_i;
        REG_KI:       ki_q       <= cfg_data_i;
        REG_KD:       kd_q       <= cfg_data_i;
        REG_INT_LIM:  int_lim_q  <= cfg_data_i[LimW-1:0];
        REG_PULL_LIM: pull_lim_q <= cfg_data_i[LimW-1:0];
        REG_MIN_STEP: min_step_q <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  opd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  opd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (s_axis_tdata_i),
    .kp_i          (kp_q),
    .ki_i          (ki_q),
    .kd_i          (kd_q),
    .int_lim_i     (int_lim_q),
    .pull_lim_i    (pull_lim_q),
    .min_step_i    (min_step_q),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_freq_o    (m_axis_tdata_o),
    .out_applied_o (applied)
  );

  assign m_axis_tuser_o = applied;

  // a freshly applied correction never exceeds the pull bound
  a_pull_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      ($signed(m_axis_tdata_o) <= $signed({1'b0, pull_lim_q}) &&
       $signed(m_axis_tdata_o) >= -$signed({1'b0, pull_lim_q})))
    else $error("applied correction beyond pull limit");
endmodule
